/* rtl/assert_macros.svh */
// Assertion helpers for the payload cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPLY(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHK_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CHK_IMPLY(lbl, clk, rst_n, prop, msg)
`define CHK_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/cpc_pkg.sv */
package cpc_pkg;

	localparam int KEY_W      = 64;
	localparam int BLK_W      = 128;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int NUM_ROUNDS = 10;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] dev_addr;
		logic        direction;
		logic [15:0] frame_counter;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	// Work item handed from the classifier to the keystream side.
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic [3:0]       pos;
		logic             new_blk;
		logic [BLK_W-1:0] ctr_blk;
	} job_t;

	typedef struct packed {
		logic busy;
		logic ks_ready;
	} back_status_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a 128-bit block sits at bits 127-8i down.
	function automatic logic [7:0] blk_byte(input logic [BLK_W-1:0] b, input logic [3:0] i);
		return b[BLK_W-1-8*i -: 8];
	endfunction

	// Next round key from the current one.
	function automatic logic [BLK_W-1:0] key_expand(input logic [BLK_W-1:0] rk,
			input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// One AES round: sub bytes, shift rows, mix columns (skipped in the final round), add key.
	function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] st,
			input logic [BLK_W-1:0] rk, input logic final_rnd);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [BLK_W-1:0] r;
		for (int i = 0; i < 16; i++) begin
			t[i] = SBOX[blk_byte(st, 4'((i % 4) + 4 * (((i / 4) + (i % 4)) % 4)))];
		end
		if (!final_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c];
				a1 = t[4*c+1];
				a2 = t[4*c+2];
				a3 = t[4*c+3];
				x = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[BLK_W-1-8*i -: 8] = t[i];
		end
		return r ^ rk;
	endfunction

endpackage

/* rtl/frame_payload_ctr_cipher_top.sv */
// Counter-mode payload cipher over AES-128. Payload bytes are pushed one word at a
// time and come back XORed with a keystream; encrypt and decrypt are the same
// operation. Mark the first byte of each frame with first_byte, which also samples
// dev_addr, direction and frame_counter; last_byte is copied to out_last and ends
// the current keystream block. Inside a 16-byte block one byte is accepted and one
// returned per cycle while the receiver keeps popping. Each new block first runs
// the counter block through one AES round unit, one round per cycle, before the
// first byte of the block leaves the head of the 4-word queue; for a long frame
// that round unit sets the pace. Input keeps flowing into the queue, until it is
// full, while the round unit works. Write the key through cfg_we/cfg_index/cfg_data
// (index 0: key bytes 0..7, index 1: key bytes 8..15, byte 0 most significant)
// only while no word is in flight; a new key applies from the next block.
`include "assert_macros.svh"

module frame_payload_ctr_cipher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpc_pkg::KEY_W-1:0]      cfg_data,
	input  logic                           push,
	output logic                           full,
	input  cpc_pkg::in_word_t              din,
	output logic                           empty,
	input  logic                           pop,
	output cpc_pkg::out_word_t             dout
);
	import cpc_pkg::*;

	logic [KEY_W-1:0] key_hi_q, key_lo_q;
	logic             accept, q_valid, q_pop, out_valid;
	job_t             new_job, head_job;
	back_status_t     bstat;

	// Key registers: hold until rewritten.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_HIGH: key_hi_q <= cfg_data;
				REG_KEY_LOW:  key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	// Classify each word: block position, block index, counter block.
	cpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.din    (din),
		.job    (new_job)
	);

	// Decouple classification from the round unit.
	cpc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (new_job),
		.full   (full),
		.rd     (q_pop),
		.valid  (q_valid),
		.head   (head_job)
	);

	// Make keystream blocks and XOR each byte; drive the result register.
	cpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       ({key_hi_q, key_lo_q}),
		.job_valid (q_valid),
		.job       (head_job),
		.job_pop   (q_pop),
		.pop       (pop),
		.out_valid (out_valid),
		.dout      (dout),
		.status    (bstat)
	);

	assign empty = !out_valid;

	// The round unit only runs for a word waiting at the queue head.
	`CHK_IMPLY(a_busy_has_job, clk, arst_n, bstat.busy |-> q_valid && head_job.new_blk, "round unit busy without a new-block word at the head")
	// A finished keystream and a running round unit never coexist.
	`CHK_NEVER(a_ready_not_busy, clk, arst_n, bstat.busy && bstat.ks_ready, "keystream ready while still encrypting")
	// A new-block word never leaves the queue before its keystream is done.
	`CHK_NEVER(a_no_early_pop, clk, arst_n, q_pop && head_job.new_blk && !bstat.ks_ready, "new-block word dequeued without keystream")

endmodule

/* rtl/cpc_front.sv */
module cpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cpc_pkg::in_word_t din,
	output cpc_pkg::job_t     job
);
	import cpc_pkg::*;

	logic [3:0]  pos_q;
	logic [7:0]  index_q;
	logic [31:0] addr_q;
	logic        dir_q;
	logic [15:0] fcnt_q;

	logic [31:0] addr;
	logic        dir;
	logic [15:0] fcnt;
	logic [7:0]  idx;
	logic [3:0]  pos;

	always_comb begin
		addr = din.first_byte ? din.dev_addr : addr_q;
		dir  = din.first_byte ? din.direction : dir_q;
		fcnt = din.first_byte ? din.frame_counter : fcnt_q;
		pos  = din.first_byte ? 4'd0 : pos_q;
		if (din.first_byte) begin
			idx = 8'd1;
		end else if (pos_q == 4'd0) begin
			idx = index_q + 8'd1;
		end else begin
			idx = index_q;
		end
		job.data    = din.data_byte;
		job.last    = din.last_byte;
		job.pos     = pos;
		job.new_blk = din.first_byte || (pos_q == 4'd0);
		job.ctr_blk = {8'h01, 32'h0, 7'h0, dir,
			addr[7:0], addr[15:8], addr[23:16], addr[31:24],
			fcnt[7:0], fcnt[15:8], 24'h0, idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			index_q <= '0;
			addr_q  <= '0;
			dir_q   <= 1'b0;
			fcnt_q  <= '0;
		end else if (accept) begin
			pos_q   <= din.last_byte ? 4'd0 : pos + 4'd1;
			index_q <= idx;
			addr_q  <= addr;
			dir_q   <= dir;
			fcnt_q  <= fcnt;
		end
	end

endmodule

/* rtl/cpc_fifo.sv */
module cpc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  cpc_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd,
	output logic          valid,
	output cpc_pkg::job_t head
);
	import cpc_pkg::*;

	job_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

endmodule

/* rtl/cpc_back.sv */
module cpc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cpc_pkg::BLK_W-1:0]   key,
	input  logic                        job_valid,
	input  cpc_pkg::job_t               job,
	output logic                        job_pop,
	input  logic                        pop,
	output logic                        out_valid,
	output cpc_pkg::out_word_t          dout,
	output cpc_pkg::back_status_t       status
);
	import cpc_pkg::*;

	logic             busy_q, ks_ready_q, out_valid_q;
	logic [3:0]       rnd_q;
	logic [7:0]       rcon_q;
	logic [BLK_W-1:0] st_q, rk_q, ks_q;
	out_word_t        out_q;

	logic             start, emit;
	logic [BLK_W-1:0] nrk, nst;

	always_comb begin
		start = job_valid && job.new_blk && !ks_ready_q && !busy_q;
		emit  = job_valid && (!job.new_blk || ks_ready_q) && (!out_valid_q || pop);
		nrk   = key_expand(rk_q, rcon_q);
		nst   = aes_round(st_q, nrk, rnd_q == 4'(NUM_ROUNDS));
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= job.ctr_blk ^ key;
			rk_q <= key;
		end else if (busy_q) begin
			st_q <= nst;
			rk_q <= nrk;
		end
		if (busy_q && rnd_q == 4'(NUM_ROUNDS)) begin
			ks_q <= nst;
		end
		if (emit) begin
			out_q.out_byte <= job.data ^ blk_byte(ks_q, job.pos);
			out_q.out_last <= job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ks_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
			rnd_q       <= '0;
			rcon_q      <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 4'd1;
				rcon_q <= 8'h01;
			end else if (busy_q) begin
				rcon_q <= xtime(rcon_q);
				rnd_q  <= rnd_q + 4'd1;
				if (rnd_q == 4'(NUM_ROUNDS)) begin
					busy_q     <= 1'b0;
					ks_ready_q <= 1'b1;
				end
			end
			if (emit) begin
				ks_ready_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign job_pop         = emit;
	assign out_valid       = out_valid_q;
	assign dout            = out_q;
	assign status.busy     = busy_q;
	assign status.ks_ready = ks_ready_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import cpc_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0] cfg_data;
	logic push;
	logic full;
	in_word_t din;
	logic empty;
	logic pop;
	out_word_t dout;

	frame_payload_ctr_cipher_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .din(din),
		.empty(empty), .pop(pop), .dout(dout)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Predictor state: key, current keystream block and frame parameters.
	logic [7:0] sub_tbl [256];
	logic [127:0] cipher_key;
	logic [127:0] keystream;
	logic [3:0] byte_pos;
	logic [7:0] block_num;
	logic [31:0] frame_addr;
	logic frame_dir;
	logic [15:0] frame_ctr;

	out_word_t expected_words [$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;

	function automatic logic [7:0] gf_mul2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc = acc ^ a;
			a = gf_mul2(a);
		end
		return acc;
	endfunction

	// Build the substitution table from the field inverse and the affine map.
	task automatic build_sub_table();
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(8'(x), 8'(y)) == 8'h01)
					inv = 8'(y);
			end
			sub_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endtask

	// AES-128 encryption; byte i of a block sits at bits 127-8i down.
	function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
			input logic [127:0] plain);
		logic [7:0] rk [176];
		logic [7:0] st [16];
		logic [7:0] sh [16];
		logic [7:0] t0, t1, t2, t3, s, rc, a0, a1, a2, a3, x;
		logic [127:0] res;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[127-8*i -: 8];
			st[i] = plain[127-8*i -: 8] ^ rk[i];
		end
		for (int i = 16; i < 176; i += 4) begin
			t0 = rk[i-4];
			t1 = rk[i-3];
			t2 = rk[i-2];
			t3 = rk[i-1];
			if (i % 16 == 0) begin
				s = t0;
				t0 = sub_tbl[t1] ^ rc;
				t1 = sub_tbl[t2];
				t2 = sub_tbl[t3];
				t3 = sub_tbl[s];
				rc = gf_mul2(rc);
			end
			rk[i] = rk[i-16] ^ t0;
			rk[i+1] = rk[i-15] ^ t1;
			rk[i+2] = rk[i-14] ^ t2;
			rk[i+3] = rk[i-13] ^ t3;
		end
		for (int r = 1; r <= 10; r++) begin
			// row j of column c comes from column c+j
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					sh[4*c+j] = sub_tbl[st[4*((c+j)%4)+j]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = sh[4*c];
					a1 = sh[4*c+1];
					a2 = sh[4*c+2];
					a3 = sh[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					sh[4*c] = a0 ^ x ^ gf_mul2(a0 ^ a1);
					sh[4*c+1] = a1 ^ x ^ gf_mul2(a1 ^ a2);
					sh[4*c+2] = a2 ^ x ^ gf_mul2(a2 ^ a3);
					sh[4*c+3] = a3 ^ x ^ gf_mul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] = sh[i] ^ rk[16*r+i];
		end
		for (int i = 0; i < 16; i++)
			res[127-8*i -: 8] = st[i];
		return res;
	endfunction

	function automatic logic [127:0] counter_block();
		logic [127:0] b;
		b = '0;
		b[127 -: 8] = 8'h01;
		b[127-8*5 -: 8] = {7'b0, frame_dir};
		b[127-8*6 -: 8] = frame_addr[7:0];
		b[127-8*7 -: 8] = frame_addr[15:8];
		b[127-8*8 -: 8] = frame_addr[23:16];
		b[127-8*9 -: 8] = frame_addr[31:24];
		b[127-8*10 -: 8] = frame_ctr[7:0];
		b[127-8*11 -: 8] = frame_ctr[15:8];
		b[7:0] = block_num;
		return b;
	endfunction

	// Advance the predictor by one accepted word and queue the ciphered byte.
	task automatic predict_cipher_byte(input in_word_t w);
		out_word_t o;
		if (w.first_byte) begin
			frame_addr = w.dev_addr;
			frame_dir = w.direction;
			frame_ctr = w.frame_counter;
			block_num = 8'd1;
			byte_pos = 4'd0;
			keystream = aes_encrypt(cipher_key, counter_block());
		end else if (byte_pos == 4'd0) begin
			block_num = block_num + 8'd1;
			keystream = aes_encrypt(cipher_key, counter_block());
		end
		o.out_byte = w.data_byte ^ keystream[127-8*byte_pos -: 8];
		o.out_last = w.last_byte;
		expected_words.push_back(o);
		byte_pos = w.last_byte ? 4'd0 : byte_pos + 4'd1;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// Push one word: idle at random, hold push until the block takes it.
	// Push stays high on return so the next word can follow at once.
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		din <= w;
		forever begin
			@(negedge clk);
			if (!full) begin
				predict_cipher_byte(w);
				@(posedge clk);
				break;
			end
			@(posedge clk);
		end
	endtask

	// Drain, let the block settle, then write one key half.
	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_KEY_HIGH)
			cipher_key[127:64] = val;
		else
			cipher_key[63:0] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom}));
		return w;
	endfunction

	// Send one well-formed frame of n bytes with random content.
	task automatic send_frame(input int n);
		in_word_t w;
		in_word_t params;
		params = random_word();
		for (int i = 0; i < n; i++) begin
			w = random_word();
			w.first_byte = (i == 0);
			w.last_byte = (i == n - 1);
			if (i == 0) begin
				w.dev_addr = params.dev_addr;
				w.direction = params.direction;
				w.frame_counter = params.frame_counter;
			end
			send_word(w);
		end
	endtask

	task automatic test_reset_stream();
		in_word_t w;
		// Words without a first mark after reset run on zero parameters, starting at index 1.
		for (int i = 0; i < 18; i++) begin
			w = random_word();
			w.first_byte = 1'b0;
			w.last_byte = 1'b0;
			w.data_byte = (i % 2) ? 8'hff : 8'h00;
			send_word(w);
		end
	endtask

	task automatic test_directed_frames();
		in_word_t w;
		write_key(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
		write_key(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
		// Extreme parameters, a frame crossing one block edge.
		for (int i = 0; i < 17; i++) begin
			w = '0;
			w.data_byte = (i % 2) ? 8'h00 : 8'hff;
			w.first_byte = (i == 0);
			w.last_byte = (i == 16);
			w.dev_addr = 32'hffff_ffff;
			w.direction = 1'b1;
			w.frame_counter = 16'hffff;
			send_word(w);
		end
		// Unmarked words after a last mark advance the index.
		for (int i = 0; i < 4; i++) begin
			w = random_word();
			w.first_byte = 1'b0;
			w.last_byte = (i == 1);
			send_word(w);
		end
		// A first mark in mid-block restarts the frame.
		send_frame(3);
		write_key(REG_KEY_HIGH, 64'h0);
		write_key(REG_KEY_LOW, 64'h0);
	endtask

	task automatic test_index_wrap();
		in_word_t w;
		send_frame(1);
		// Each single last-marked word opens a new block; drive the index past 255.
		for (int i = 0; i < 260; i++) begin
			w = random_word();
			w.first_byte = 1'b0;
			w.last_byte = 1'b1;
			send_word(w);
		end
	endtask

	task automatic test_random_traffic();
		in_word_t w;
		int sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 78;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 78;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			write_key(REG_KEY_HIGH, {$urandom, $urandom});
			write_key(REG_KEY_LOW, {$urandom, $urandom});
			sent = 0;
			while (sent < 230) begin
				if ($urandom_range(9) < 8) begin
					// mostly short frames, now and then a long one
					w.data_byte = 8'($urandom_range(9) == 0 ? $urandom_range(40, 70)
						: $urandom_range(1, 20));
					send_frame(w.data_byte);
					sent += w.data_byte;
				end else begin
					w = random_word();
					send_word(w);
					sent++;
				end
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver: stall at random; compare each accepted word with the oldest expectation.
	always @(posedge clk)
		pop <= ($urandom_range(99) >= recv_stall_pct);

	always @(negedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 16'(dout), 16'h0);
			end else begin
				want = expected_words.pop_front();
				if (dout.out_byte !== want.out_byte)
					report_mismatch("out_byte", 16'(dout.out_byte), 16'(want.out_byte));
				if (dout.out_last !== want.out_last)
					report_mismatch("out_last", 16'(dout.out_last), 16'(want.out_last));
			end
		end
	end

	// Watchdog: count cycles with no word moving on either side.
	always @(negedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cipher_key = '0;
		keystream = '0;
		byte_pos = '0;
		block_num = '0;
		frame_addr = '0;
		frame_dir = 1'b0;
		frame_ctr = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		push <= 1'b0;
		din <= '0;
		build_sub_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_stream();
		test_directed_frames();
		test_index_wrap();
		test_random_traffic();

		// Drain, then allow stray words to show up.
		push <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
